// ===== hdl/ppls_pkg.sv =====
// shared constants, payload types and config record for the phong shading core
// no dependencies; every other file refers to this package by scoped names

package ppls_pkg;

	// field widths
	localparam int POS_W  = 20;
	localparam int VEC_W  = 16;
	localparam int CH_W   = 16;
	localparam int COEF_W = 16;
	localparam int SHIN_W = 8;
	localparam int OUT_W  = 18;
	localparam int FRAC   = 14;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;
	localparam int LPOS_W     = 3 * POS_W;
	localparam int RGB_W      = 3 * CH_W;

	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POSITION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_INTENSITY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_COLOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_COEFF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_COEFF   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_COEFF  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHININESS_EXP   = 3'd6;

	localparam logic [RGB_W-1:0]  RGB_ONE_RESET  = 48'h4000_4000_4000;
	localparam logic [COEF_W-1:0] AMBIENT_RESET  = 16'd1638;
	localparam logic [COEF_W-1:0] DIFFUSE_RESET  = 16'd14746;
	localparam logic [COEF_W-1:0] SPECULAR_RESET = 16'd14746;
	localparam logic [SHIN_W-1:0] SHININESS_RESET = 8'd200;

	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// internal datapath widths
	localparam int MAG_W  = POS_W;          // |light - point|
	localparam int SUM_W  = 2 * MAG_W + 2;  // squared length
	localparam int RX_W   = SUM_W + 21;     // radicand s << 20, one spare bit
	localparam int ROOT_W = 31;             // floor sqrt of the radicand
	localparam int Q_W    = 15;             // light vector magnitude, at most 1.0
	localparam int DV_W   = MAG_W + 24 + 2; // divider remainder and trial
	localparam int L_W    = Q_W + 1;
	localparam int NDL_W  = 34;
	localparam int DL_W   = 18;
	localparam int R_W    = 36;
	localparam int RDE_W  = 54;
	localparam int RE_W   = 24;
	localparam int P_W    = 32;
	localparam int DR_W   = 20;
	localparam int SR_W   = 34;
	localparam int EFF_W  = 18;
	localparam int AMB_W  = 20;
	localparam int DIFF_W = 24;
	localparam int SPEC_W = 36;
	localparam int TOT_W  = SPEC_W + 1;
	localparam int POW_STEPS = (1 << SHIN_W) - 1;

	localparam logic [P_W-1:0]   ONE_Q14 = P_W'(1 << FRAC);
	localparam logic [P_W-1:0]   POW_CAP = '1;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef struct packed {
		logic signed [POS_W-1:0] point_x;
		logic signed [POS_W-1:0] point_y;
		logic signed [POS_W-1:0] point_z;
		logic signed [VEC_W-1:0] normal_x;
		logic signed [VEC_W-1:0] normal_y;
		logic signed [VEC_W-1:0] normal_z;
		logic signed [VEC_W-1:0] eye_x;
		logic signed [VEC_W-1:0] eye_y;
		logic signed [VEC_W-1:0] eye_z;
		logic                    shadowed;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic [SUM_W-1:0]      sum_sq;
		logic [2:0][VEC_W-1:0] normal;
		logic [2:0][VEC_W-1:0] eye;
		logic                  shadowed;
	} qitem_t;

	typedef struct packed {
		logic [LPOS_W-1:0] light_position;
		logic [RGB_W-1:0]  light_intensity;
		logic [RGB_W-1:0]  surface_color;
		logic [COEF_W-1:0] ambient_coeff;
		logic [COEF_W-1:0] diffuse_coeff;
		logic [COEF_W-1:0] specular_coeff;
		logic [SHIN_W-1:0] shininess_exp;
	} cfg_t;

	// one 16-bit channel of a packed rgb register
	function automatic logic [CH_W-1:0] chan(input logic [RGB_W-1:0] packed_rgb,
		input int c);
		return packed_rgb[c*CH_W +: CH_W];
	endfunction

endpackage

// ===== hdl/ppls_if.sv =====
// valid/ready stream interfaces for the phong shading core channels
// depends on ppls_pkg for the payload types

interface ppls_in_if;
	logic                 valid;
	logic                 ready;
	ppls_pkg::in_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ppls_queue_if;
	logic                 valid;
	logic                 ready;
	ppls_pkg::qitem_t     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ppls_out_if;
	logic                 valid;
	logic                 ready;
	ppls_pkg::out_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/phong_point_light_shading_core.sv =====
// phong point-light shading core: throughput one sample per cycle while the output is not
// stalled, set by the fully pipelined sqrt (31 stages), divide (15 stages) and power chain
// (255 multiply stages, one per exponent step)
// output stall freezes the back pipeline; the front keeps filling the queue until full
// reset clears valid bits and queue pointers and loads the config defaults; no clearing pass
// depends on ppls_pkg, ppls_if, ppls_front, ppls_queue and ppls_back

module phong_point_light_shading_core #(
	parameter int QUEUE_DEPTH = ppls_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ppls_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppls_pkg::CFG_DATA_W-1:0]    cfg_data,
	ppls_in_if.sink                            in_stream,
	ppls_out_if.source                         out_stream
);

	ppls_pkg::cfg_t cfg_q;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_position  <= '0;
			cfg_q.light_intensity <= ppls_pkg::RGB_ONE_RESET;
			cfg_q.surface_color   <= ppls_pkg::RGB_ONE_RESET;
			cfg_q.ambient_coeff   <= ppls_pkg::AMBIENT_RESET;
			cfg_q.diffuse_coeff   <= ppls_pkg::DIFFUSE_RESET;
			cfg_q.specular_coeff  <= ppls_pkg::SPECULAR_RESET;
			cfg_q.shininess_exp   <= ppls_pkg::SHININESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ppls_pkg::REG_LIGHT_POSITION: begin
					cfg_q.light_position <= cfg_data[ppls_pkg::LPOS_W-1:0];
				end
				ppls_pkg::REG_LIGHT_INTENSITY: begin
					cfg_q.light_intensity <= cfg_data[ppls_pkg::RGB_W-1:0];
				end
				ppls_pkg::REG_SURFACE_COLOR: begin
					cfg_q.surface_color <= cfg_data[ppls_pkg::RGB_W-1:0];
				end
				ppls_pkg::REG_AMBIENT_COEFF: begin
					cfg_q.ambient_coeff <= cfg_data[ppls_pkg::COEF_W-1:0];
				end
				ppls_pkg::REG_DIFFUSE_COEFF: begin
					cfg_q.diffuse_coeff <= cfg_data[ppls_pkg::COEF_W-1:0];
				end
				ppls_pkg::REG_SPECULAR_COEFF: begin
					cfg_q.specular_coeff <= cfg_data[ppls_pkg::COEF_W-1:0];
				end
				ppls_pkg::REG_SHININESS_EXP: begin
					cfg_q.shininess_exp <= cfg_data[ppls_pkg::SHIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ppls_queue_if q_in ();
	ppls_queue_if q_out ();

	ppls_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.light_position (cfg_q.light_position),
		.in_stream      (in_stream),
		.q_stream       (q_in)
	);

	ppls_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_in),
		.rd     (q_out)
	);

	ppls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_stream   (q_out),
		.out_stream (out_stream)
	);

endmodule

// ===== hdl/ppls_front.sv =====
// front end: takes samples, forms the light offset and its squared length
// depends on ppls_pkg and ppls_if

module ppls_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ppls_pkg::LPOS_W-1:0]     light_position,
	ppls_in_if.sink                         in_stream,
	ppls_queue_if.source                    q_stream
);

	localparam int POS_W = ppls_pkg::POS_W;
	localparam int SUM_W = ppls_pkg::SUM_W;

	logic                  fe;
	logic                  v_s1, v_s2;
	ppls_pkg::qitem_t      item_s1, item_s2;
	logic [2:0][POS_W-1:0] lp_a, pt_a;
	logic signed [POS_W:0] d [3];
	logic [2:0][POS_W-1:0] mag_c;
	logic [2:0]            neg_c;
	logic [SUM_W-1:0]      m0, m1, m2;

	// both stages move together unless the queue refuses the head
	assign fe = !(v_s2 && !q_stream.ready);
	assign in_stream.ready = fe;

	// offset from point to light, split into sign and magnitude
	always_comb begin
		pt_a = {in_stream.data.point_z, in_stream.data.point_y, in_stream.data.point_x};
		for (int i = 0; i < 3; i++) begin
			lp_a[i] = light_position[i*POS_W +: POS_W];
			d[i] = $signed({lp_a[i][POS_W-1], lp_a[i]}) - $signed({pt_a[i][POS_W-1], pt_a[i]});
			neg_c[i] = d[i][POS_W];
			mag_c[i] = d[i][POS_W] ? POS_W'(-d[i]) : d[i][POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fe) begin
			v_s1 <= in_stream.valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (fe) begin
			item_s1.mag      <= mag_c;
			item_s1.neg      <= neg_c;
			item_s1.sum_sq   <= '0;
			item_s1.normal   <= {in_stream.data.normal_z, in_stream.data.normal_y,
				in_stream.data.normal_x};
			item_s1.eye      <= {in_stream.data.eye_z, in_stream.data.eye_y,
				in_stream.data.eye_x};
			item_s1.shadowed <= in_stream.data.shadowed;
		end
	end

	// squared length of the offset
	assign m0 = SUM_W'(item_s1.mag[0]);
	assign m1 = SUM_W'(item_s1.mag[1]);
	assign m2 = SUM_W'(item_s1.mag[2]);

	always_ff @(posedge clk) begin
		if (fe) begin
			item_s2.mag      <= item_s1.mag;
			item_s2.neg      <= item_s1.neg;
			item_s2.normal   <= item_s1.normal;
			item_s2.eye      <= item_s1.eye;
			item_s2.shadowed <= item_s1.shadowed;
			item_s2.sum_sq   <= m0 * m0 + m1 * m1 + m2 * m2;
		end
	end

	assign q_stream.valid = v_s2;
	assign q_stream.data  = item_s2;

endmodule

// ===== hdl/ppls_queue.sv =====
// short register queue between the front end and the shading pipeline
// depends on ppls_pkg and ppls_if

module ppls_queue #(
	parameter int DEPTH = ppls_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	ppls_queue_if.sink   wr,
	ppls_queue_if.source rd
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ppls_pkg::qitem_t  mem_q [DEPTH];
	logic [IDX_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push, pop;

	assign wr.ready = (count_q != CNT_W'(DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.data  = mem_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

endmodule

// ===== hdl/ppls_back.sv =====
// shading pipeline: sqrt, light vector divide, dot products, power chain, sums
// depends on ppls_pkg and ppls_if

module ppls_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ppls_pkg::cfg_t cfg,
	ppls_queue_if.sink     q_stream,
	ppls_out_if.source     out_stream
);

	localparam int MAG_W  = ppls_pkg::MAG_W;
	localparam int VEC_W  = ppls_pkg::VEC_W;
	localparam int SUM_W  = ppls_pkg::SUM_W;
	localparam int RX_W   = ppls_pkg::RX_W;
	localparam int ROOT_W = ppls_pkg::ROOT_W;
	localparam int Q_W    = ppls_pkg::Q_W;
	localparam int DV_W   = ppls_pkg::DV_W;
	localparam int L_W    = ppls_pkg::L_W;
	localparam int NDL_W  = ppls_pkg::NDL_W;
	localparam int DL_W   = ppls_pkg::DL_W;
	localparam int R_W    = ppls_pkg::R_W;
	localparam int RDE_W  = ppls_pkg::RDE_W;
	localparam int RE_W   = ppls_pkg::RE_W;
	localparam int P_W    = ppls_pkg::P_W;
	localparam int DR_W   = ppls_pkg::DR_W;
	localparam int SR_W   = ppls_pkg::SR_W;
	localparam int EFF_W  = ppls_pkg::EFF_W;
	localparam int AMB_W  = ppls_pkg::AMB_W;
	localparam int DIFF_W = ppls_pkg::DIFF_W;
	localparam int SPEC_W = ppls_pkg::SPEC_W;
	localparam int TOT_W  = ppls_pkg::TOT_W;
	localparam int CH_W   = ppls_pkg::CH_W;
	localparam int COEF_W = ppls_pkg::COEF_W;
	localparam int SHIN_W = ppls_pkg::SHIN_W;
	localparam int OUT_W  = ppls_pkg::OUT_W;
	localparam int FRAC   = ppls_pkg::FRAC;
	localparam int DIV_STEPS = Q_W;
	localparam int POW_STEPS = ppls_pkg::POW_STEPS;
	localparam int PX_W   = P_W + RE_W;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic [2:0][VEC_W-1:0] normal;
		logic [2:0][VEC_W-1:0] eye;
		logic                  shadowed;
		logic                  zero;
	} geo_t;

	typedef struct packed {
		logic [RE_W-1:0] re;
		logic            spec_on;
		logic            diff_on;
		logic [DR_W-1:0] dratio;
	} pw_t;

	logic be;
	logic v_s6;

	// whole pipeline advances unless the output holds an untaken result
	assign be = !v_s6 || out_stream.ready;
	assign q_stream.ready = be;

	// config-derived colors, settled long before any item reaches the sums
	logic [EFF_W-1:0] eff_q [3];
	logic [AMB_W-1:0] amb_q [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			eff_q[i] <= EFF_W'((32'(ppls_pkg::chan(cfg.surface_color, i)) *
				32'(ppls_pkg::chan(cfg.light_intensity, i))) >> FRAC);
			amb_q[i] <= AMB_W'((34'(eff_q[i]) * 34'(cfg.ambient_coeff)) >> FRAC);
		end
	end

	// square root, one result bit per stage
	logic              sq_v_s   [ROOT_W+1];
	logic [RX_W-1:0]   sq_rem_s [ROOT_W+1];
	logic [ROOT_W-1:0] root_s   [ROOT_W+1];
	geo_t              sq_geo_s [ROOT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (be) begin
			sq_v_s[0] <= q_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			sq_rem_s[0]          <= {1'b0, q_stream.data.sum_sq, 20'b0};
			root_s[0]            <= '0;
			sq_geo_s[0].mag      <= q_stream.data.mag;
			sq_geo_s[0].neg      <= q_stream.data.neg;
			sq_geo_s[0].normal   <= q_stream.data.normal;
			sq_geo_s[0].eye      <= q_stream.data.eye;
			sq_geo_s[0].shadowed <= q_stream.data.shadowed;
			sq_geo_s[0].zero     <= (q_stream.data.sum_sq == '0);
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int J = ROOT_W - 1 - k;
		logic [RX_W-1:0] trial;
		assign trial = (RX_W'(root_s[k]) << (J + 1)) + (RX_W'(1) << (2 * J));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (be) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (be) begin
				sq_geo_s[k+1] <= sq_geo_s[k];
				if (sq_rem_s[k] >= trial) begin
					sq_rem_s[k+1] <= sq_rem_s[k] - trial;
					root_s[k+1]   <= root_s[k] | (ROOT_W'(1) << J);
				end else begin
					sq_rem_s[k+1] <= sq_rem_s[k];
					root_s[k+1]   <= root_s[k];
				end
			end
		end
	end

	// light vector magnitudes, restoring divide on three lanes
	logic              dv_v_s   [DIV_STEPS+1];
	logic [DV_W-1:0]   dv_rem_s [DIV_STEPS+1][3];
	logic [Q_W-1:0]    dv_q_s   [DIV_STEPS+1][3];
	logic [ROOT_W-1:0] dv_len_s [DIV_STEPS+1];
	geo_t              dv_geo_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (be) begin
			dv_v_s[0] <= sq_v_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			dv_len_s[0] <= root_s[ROOT_W];
			dv_geo_s[0] <= sq_geo_s[ROOT_W];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= DV_W'({sq_geo_s[ROOT_W].mag[i], 24'b0});
				dv_q_s[0][i]   <= '0;
			end
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int B = DIV_STEPS - 1 - k;
		logic [DV_W-1:0] dtrial;
		assign dtrial = DV_W'(dv_len_s[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (be) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (be) begin
				dv_len_s[k+1] <= dv_len_s[k];
				dv_geo_s[k+1] <= dv_geo_s[k];
				for (int i = 0; i < 3; i++) begin
					if (dv_rem_s[k][i] >= dtrial) begin
						dv_rem_s[k+1][i] <= dv_rem_s[k][i] - dtrial;
						dv_q_s[k+1][i]   <= dv_q_s[k][i] | (Q_W'(1) << B);
					end else begin
						dv_rem_s[k+1][i] <= dv_rem_s[k][i];
						dv_q_s[k+1][i]   <= dv_q_s[k][i];
					end
				end
			end
		end
	end

	// dot stage 1: signed light vector and its dot with the normal
	geo_t                    geo_d;
	logic signed [L_W-1:0]   lv_c [3];
	logic signed [NDL_W-1:0] ndl_c;
	logic                    v_s1, v_s2, v_s3;
	logic signed [L_W-1:0]   l_s1 [3];
	logic signed [NDL_W-1:0] ndl_s1;
	logic [2:0][VEC_W-1:0]   normal_s1, eye_s1, eye_s2;
	logic                    shadowed_s1;

	assign geo_d = dv_geo_s[DIV_STEPS];

	always_comb begin
		ndl_c = '0;
		for (int i = 0; i < 3; i++) begin
			if (geo_d.zero) begin
				lv_c[i] = '0;
			end else if (geo_d.neg[i]) begin
				lv_c[i] = -$signed({1'b0, dv_q_s[DIV_STEPS][i]});
			end else begin
				lv_c[i] = $signed({1'b0, dv_q_s[DIV_STEPS][i]});
			end
			ndl_c = ndl_c + NDL_W'(lv_c[i]) * NDL_W'($signed(geo_d.normal[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			l_s1        <= lv_c;
			ndl_s1      <= ndl_c;
			normal_s1   <= geo_d.normal;
			eye_s1      <= geo_d.eye;
			shadowed_s1 <= geo_d.shadowed;
		end
	end

	// dot stage 2: reflected vector and diffuse ratio
	logic [DL_W-1:0]             dl_c;
	logic signed [R_W-1:0]       r_c [3];
	logic [COEF_W+DL_W-1:0]      dprod_c;
	logic signed [R_W-1:0]       r_s2 [3];
	logic                        diff_on_s2;
	logic [DR_W-1:0]             dratio_s2;

	assign dl_c    = ndl_s1[FRAC +: DL_W];
	assign dprod_c = (COEF_W+DL_W)'(cfg.diffuse_coeff) * (COEF_W+DL_W)'(dl_c);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_c[i] = ((R_W'($signed(normal_s1[i])) * $signed(R_W'(dl_c))) <<< 1) -
				(R_W'(l_s1[i]) <<< FRAC);
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			r_s2       <= r_c;
			diff_on_s2 <= !shadowed_s1 && !ndl_s1[NDL_W-1];
			dratio_s2  <= dprod_c[FRAC +: DR_W];
			eye_s2     <= eye_s1;
		end
	end

	// dot stage 3: reflection against eye, seeds the power chain
	logic signed [RDE_W-1:0] rde_c;
	logic                    pw_v_s [POW_STEPS+1];
	logic [P_W-1:0]          pw_p_s [POW_STEPS+1];
	pw_t                     pw_s   [POW_STEPS+1];

	always_comb begin
		rde_c = '0;
		for (int i = 0; i < 3; i++) begin
			rde_c = rde_c + RDE_W'(r_s2[i]) * RDE_W'($signed(eye_s2[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (be) begin
			v_s1 <= dv_v_s[DIV_STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign pw_v_s[0] = v_s3;

	always_ff @(posedge clk) begin
		if (be) begin
			pw_p_s[0]         <= ppls_pkg::ONE_Q14;
			pw_s[0].re        <= rde_c[28 +: RE_W];
			pw_s[0].spec_on   <= diff_on_s2 && !rde_c[RDE_W-1];
			pw_s[0].diff_on   <= diff_on_s2;
			pw_s[0].dratio    <= dratio_s2;
		end
	end

	// integer power, one truncating, saturating multiply per stage below the exponent
	for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
		logic [PX_W-1:0]      prod;
		logic [PX_W-FRAC-1:0] scaled;
		logic [P_W-1:0]       nxt;
		assign prod   = PX_W'(pw_p_s[k]) * PX_W'(pw_s[k].re);
		assign scaled = prod[PX_W-1:FRAC];
		assign nxt    = (scaled > (PX_W-FRAC)'(ppls_pkg::POW_CAP)) ? ppls_pkg::POW_CAP :
			scaled[P_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pw_v_s[k+1] <= 1'b0;
			end else if (be) begin
				pw_v_s[k+1] <= pw_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (be) begin
				pw_s[k+1]   <= pw_s[k];
				pw_p_s[k+1] <= (cfg.shininess_exp > SHIN_W'(k)) ? nxt : pw_p_s[k];
			end
		end
	end

	// stage 4: specular ratio
	logic                   v_s4, v_s5;
	logic [COEF_W+P_W-1:0]  sprod_c;
	logic [SR_W-1:0]        sratio_s4;
	logic                   spec_on_s4, diff_on_s4;
	logic [DR_W-1:0]        dratio_s4;

	assign sprod_c = (COEF_W+P_W)'(cfg.specular_coeff) * (COEF_W+P_W)'(pw_p_s[POW_STEPS]);

	always_ff @(posedge clk) begin
		if (be) begin
			sratio_s4  <= sprod_c[FRAC +: SR_W];
			spec_on_s4 <= pw_s[POW_STEPS].spec_on;
			diff_on_s4 <= pw_s[POW_STEPS].diff_on;
			dratio_s4  <= pw_s[POW_STEPS].dratio;
		end
	end

	// stage 5: per-channel diffuse and specular terms
	logic [SPEC_W-1:0] spec_s5 [3];
	logic [DIFF_W-1:0] diff_s5 [3];

	always_ff @(posedge clk) begin
		if (be) begin
			for (int i = 0; i < 3; i++) begin
				spec_s5[i] <= spec_on_s4 ? SPEC_W'(((CH_W+SR_W)'(
					ppls_pkg::chan(cfg.light_intensity, i)) * (CH_W+SR_W)'(sratio_s4)) >> FRAC) :
					'0;
				diff_s5[i] <= diff_on_s4 ? DIFF_W'(((EFF_W+DR_W)'(eff_q[i]) *
					(EFF_W+DR_W)'(dratio_s4)) >> FRAC) : '0;
			end
		end
	end

	// stage 6: sum and saturate into the output register
	logic [TOT_W-1:0]    tot_c [3];
	logic [OUT_W-1:0]    sat_c [3];
	ppls_pkg::out_item_t color_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot_c[i] = TOT_W'(amb_q[i]) + TOT_W'(diff_s5[i]) + TOT_W'(spec_s5[i]);
			sat_c[i] = (tot_c[i] > TOT_W'(ppls_pkg::OUT_MAX)) ? ppls_pkg::OUT_MAX :
				tot_c[i][OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (be) begin
			v_s4 <= pw_v_s[POW_STEPS];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			color_s6.red   <= sat_c[0];
			color_s6.green <= sat_c[1];
			color_s6.blue  <= sat_c[2];
		end
	end

	assign out_stream.valid = v_s6;
	assign out_stream.data  = color_s6;

endmodule

// ===== hdl/ppls_checker.sv =====
// port-level checks for the phong shading core, attached by bind
// depends on ppls_pkg and the top level port names

module ppls_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input ppls_pkg::out_item_t out_data
);

	logic [15:0] pend_q;
	logic        in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// samples taken but not yet returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != '0)
		else $error("result transfer with no sample outstanding");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == '0 |-> in_ready)
		else $error("input not ready while core is empty");

endmodule

bind phong_point_light_shading_core ppls_checker u_ppls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_stream.valid),
	.in_ready  (in_stream.ready),
	.out_valid (out_stream.valid),
	.out_ready (out_stream.ready),
	.out_data  (out_stream.data)
);
